/* design/phic_pkg.sv */
// ----------------------------------------------------------------------------
// phic_pkg
// Shared types, constants and helpers for the pad input history conditioner.
// ----------------------------------------------------------------------------
package phic_pkg;

  // Block dimensions
  localparam int NUM_PORTS     = 4;
  localparam int HISTORY_DEPTH = 20;
  localparam int PORT_IDX_W    = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  // Field and register widths
  localparam int BTN_W   = 16;
  localparam int DIR_W   = 4;
  localparam int CNT_W   = 8;
  localparam int THR_W   = 7;
  localparam int MODE_W  = 4;
  localparam int CFG_W   = 7;
  localparam int CFG_IDX_W = 2;

  // Constants
  localparam logic [BTN_W-1:0] DPAD_MASK   = 16'h0F00;
  localparam logic [CNT_W-1:0] COUNT_MAX   = 8'hFF;
  localparam logic [THR_W-1:0] DIR_THR_RST = 7'd20;
  localparam logic [THR_W-1:0] STR_THR_RST = 7'd50;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STICK_MODE = 2'd0,
    REG_DIR_THR    = 2'd1,
    REG_STRONG_THR = 2'd2
  } cfg_reg_e;

  // Input item
  typedef struct packed {
    logic [1:0]        controller;
    logic              connected;
    logic [BTN_W-1:0]  buttons;
    logic signed [7:0] stick_x;
    logic signed [7:0] stick_y;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [1:0]       port;
    logic [BTN_W-1:0] held_buttons;
    logic [BTN_W-1:0] new_buttons;
    logic [DIR_W-1:0] stick_dir;
    logic [DIR_W-1:0] new_stick_dir;
    logic             history_shifted;
    logic [BTN_W-1:0] head_value;
    logic [CNT_W-1:0] head_hold_count;
    logic             head_strong;
  } out_item_t;

  // One history entry
  typedef struct packed {
    logic [BTN_W-1:0] value;
    logic [CNT_W-1:0] count;
    logic             tilt;
  } hist_entry_t;

  // Control handed to every history cell
  typedef struct packed {
    logic                  upd;
    logic [PORT_IDX_W-1:0] port;
  } cell_ctrl_t;

  // Front-end results for the current item
  typedef struct packed {
    logic [DIR_W-1:0] dir;
    logic [DIR_W-1:0] new_dir;
    logic [BTN_W-1:0] new_buttons;
    logic [BTN_W-1:0] head_value;
    logic             tilt;
    logic             shifted;
  } front_t;

  // Stick thresholding: bit0 right, bit1 left, bit2 down, bit3 up
  function automatic logic [DIR_W-1:0] dir_bits(input logic signed [7:0] x,
                                                input logic signed [7:0] y,
                                                input logic [THR_W-1:0] t);
    logic signed [8:0] xs;
    logic signed [8:0] ys;
    logic signed [8:0] tp;
    logic signed [8:0] tn;
    xs = {x[7], x};
    ys = {y[7], y};
    tp = $signed({2'b00, t});
    tn = -tp;
    dir_bits[0] = (xs > tp);
    dir_bits[1] = (xs < tn);
    dir_bits[2] = (ys < tn);
    dir_bits[3] = (ys > tp);
  endfunction

endpackage

/* design/pad_input_history_conditioner_core.sv */
// ----------------------------------------------------------------------------
// pad_input_history_conditioner_core
// Gamepad sample conditioner: direction thresholds, edge detection and a
// per-port history kept in a chain of depth cells.
// ----------------------------------------------------------------------------
//   channel | signals                              | item
//   --------+--------------------------------------+---------------------
//   in      | in_valid_i / in_ready_o / in_item_i  | one pad sample
//   out     | out_valid_o / out_ready_i / out_item_o | one result
//   cfg     | cfg_we_i / cfg_idx_i / cfg_wdata_i   | register write
//
// The sample is accepted, the port's head cell is read, updated and the
// history chain shifted at the same edge; the result shows in the output
// register the next cycle. Input is taken whenever the output register is
// empty or being emptied. Disconnected samples are consumed with no result.
// Reset clears all history and previous-sample state at once.
// ----------------------------------------------------------------------------
module pad_input_history_conditioner_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  phic_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output phic_pkg::out_item_t           out_item_o,
  input  logic                          cfg_we_i,
  input  logic [phic_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [phic_pkg::CFG_W-1:0]    cfg_wdata_i
);
  import phic_pkg::*;

  logic [MODE_W-1:0] mode_q;
  logic [THR_W-1:0]  dir_thr_q;
  logic [THR_W-1:0]  str_thr_q;

  logic              out_valid_q;
  out_item_t         out_item_q;

  logic                  accept;
  logic                  active;
  logic                  port_ok;
  logic [PORT_IDX_W-1:0] port;
  front_t                front;
  hist_entry_t           head_old;
  hist_entry_t           head_upd;
  hist_entry_t           head_new;
  hist_entry_t           chain [HISTORY_DEPTH];
  cell_ctrl_t            head_ctrl;
  cell_ctrl_t            shift_ctrl;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= '0;
      dir_thr_q <= DIR_THR_RST;
      str_thr_q <= STR_THR_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_STICK_MODE: mode_q    <= cfg_wdata_i[MODE_W-1:0];
        REG_DIR_THR:    dir_thr_q <= cfg_wdata_i[THR_W-1:0];
        REG_STRONG_THR: str_thr_q <= cfg_wdata_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake and item qualification
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign port_ok    = (32'(in_item_i.controller) < NUM_PORTS);
  assign active     = accept && in_item_i.connected && port_ok;
  assign port       = PORT_IDX_W'(in_item_i.controller);

  phic_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (in_item_i),
    .port_i       (port),
    .stick_mode_i (mode_q[in_item_i.controller]),
    .dir_thr_i    (dir_thr_q),
    .str_thr_i    (str_thr_q),
    .upd_i        (active),
    .front_o      (front)
  );

  // Refreshed head entry with a held count; a shift pushes it one deeper
  // and leaves a cleared head behind
  always_comb begin
    head_upd.value = front.head_value;
    head_upd.count = (head_old.count == COUNT_MAX) ? COUNT_MAX
                                                   : head_old.count + 8'd1;
    head_upd.tilt  = front.tilt;
    if (front.shifted) begin
      head_new = '0;
    end else begin
      head_new = head_upd;
    end
  end

  assign head_ctrl.upd   = active;
  assign head_ctrl.port  = port;
  assign shift_ctrl.upd  = active && front.shifted;
  assign shift_ctrl.port = port;

  // History chain: cell 0 is the head, deeper cells take their neighbor
  phic_cell u_head (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (head_ctrl),
    .entry_i (head_new),
    .entry_o (chain[0])
  );
  assign head_old = chain[0];

  for (genvar j = 1; j < HISTORY_DEPTH; j++) begin : g_cell
    phic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (shift_ctrl),
      .entry_i ((j == 1) ? head_upd : chain[j-1]),
      .entry_o (chain[j])
    );
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (active) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (active) begin
      out_item_q.port            <= in_item_i.controller;
      out_item_q.held_buttons    <= in_item_i.buttons;
      out_item_q.new_buttons     <= front.new_buttons;
      out_item_q.stick_dir       <= front.dir;
      out_item_q.new_stick_dir   <= front.new_dir;
      out_item_q.history_shifted <= front.shifted;
      out_item_q.head_value      <= head_new.value;
      out_item_q.head_hold_count <= head_new.count;
      out_item_q.head_strong     <= head_new.tilt;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

/* design/phic_cell.sv */
// ----------------------------------------------------------------------------
// phic_cell
// One history depth stage: holds this depth's entry for every port and
// presents the selected port's entry to its deeper neighbor.
// ----------------------------------------------------------------------------
module phic_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  phic_pkg::cell_ctrl_t ctrl_i,
  input  phic_pkg::hist_entry_t entry_i,
  output phic_pkg::hist_entry_t entry_o
);
  import phic_pkg::*;

  hist_entry_t entry_q [NUM_PORTS];

  // Entry of the addressed port, before this cycle's update
  assign entry_o = entry_q[ctrl_i.port];

  // Load from the shallower neighbor (or the head logic)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PORTS; p++) begin
        entry_q[p] <= '0;
      end
    end else if (ctrl_i.upd) begin
      entry_q[ctrl_i.port] <= entry_i;
    end
  end

endmodule

/* design/phic_front.sv */
// ----------------------------------------------------------------------------
// phic_front
// Per-port previous buttons and direction, stick thresholding, edge
// detection, head candidate value and shift decision.
// ----------------------------------------------------------------------------
module phic_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  phic_pkg::in_item_t             item_i,
  input  logic [phic_pkg::PORT_IDX_W-1:0] port_i,
  input  logic                           stick_mode_i,
  input  logic [phic_pkg::THR_W-1:0]     dir_thr_i,
  input  logic [phic_pkg::THR_W-1:0]     str_thr_i,
  input  logic                           upd_i,
  output phic_pkg::front_t               front_o
);
  import phic_pkg::*;

  logic [BTN_W-1:0] prev_btn_q [NUM_PORTS];
  logic [DIR_W-1:0] prev_dir_q [NUM_PORTS];

  logic [BTN_W-1:0] prev_btn;
  logic [DIR_W-1:0] prev_dir;
  logic [DIR_W-1:0] dir;
  logic [BTN_W-1:0] drive;

  assign prev_btn = prev_btn_q[port_i];
  assign prev_dir = prev_dir_q[port_i];
  assign dir      = dir_bits(item_i.stick_x, item_i.stick_y, dir_thr_i);

  // Drive word and head candidate depend on the port's mode
  always_comb begin
    if (stick_mode_i) begin
      drive              = {4'b0000, dir, 8'h00};
      front_o.head_value = {4'b0000, prev_dir, 8'h00};
      front_o.tilt       = (dir_bits(item_i.stick_x, item_i.stick_y, str_thr_i) != '0);
    end else begin
      drive              = item_i.buttons;
      front_o.head_value = prev_btn;
      front_o.tilt       = 1'b0;
    end
    front_o.dir         = dir;
    front_o.new_dir     = (prev_dir ^ dir) & dir;
    front_o.new_buttons = (prev_btn ^ item_i.buttons) & item_i.buttons;
    front_o.shifted     = ((prev_btn & DPAD_MASK) != (drive & DPAD_MASK));
  end

  // Previous sample per port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PORTS; p++) begin
        prev_btn_q[p] <= '0;
        prev_dir_q[p] <= '0;
      end
    end else if (upd_i) begin
      prev_btn_q[port_i] <= item_i.buttons;
      prev_dir_q[port_i] <= dir;
    end
  end

endmodule

/* tb/pad_input_history_conditioner_core_tb.sv */
// ----------------------------------------------------------------------------
// pad_input_history_conditioner_core_tb
// Self-checking bench for the pad sample conditioner. A queue of pad samples
// feeds a valid/ready driver. A scoreboard model of thresholds, edge detection
// and per-port history predicts each result. A monitor compares the results
// field by field while both sides stall at random.
// ----------------------------------------------------------------------------
module pad_input_history_conditioner_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import phic_pkg::*;

  // DUT connections
  logic       clk_i;
  logic       rst_ni    = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready_o;
  in_item_t   in_item   = '0;
  logic       out_valid_o;
  logic       out_ready = 1'b0;
  out_item_t  out_item_o;
  logic       cfg_we    = 1'b0;
  cfg_reg_e   cfg_idx   = REG_STICK_MODE;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // Samples waiting to be offered, results waiting to arrive
  in_item_t  pending_samples[$];
  out_item_t expected_results[$];

  // Shadow of the register settings
  logic [MODE_W-1:0] cfg_mode_mask  = '0;
  logic [THR_W-1:0]  cfg_dir_thr    = DIR_THR_RST;
  logic [THR_W-1:0]  cfg_strong_thr = STR_THR_RST;

  // Shadow of the per-port state
  logic [BTN_W-1:0] last_btn [NUM_PORTS];
  logic [DIR_W-1:0] last_dir [NUM_PORTS];
  logic             shift_seen [NUM_PORTS];
  logic [BTN_W-1:0] hist_val [NUM_PORTS][HISTORY_DEPTH];
  logic [CNT_W-1:0] hist_cnt [NUM_PORTS][HISTORY_DEPTH];
  logic             hist_str [NUM_PORTS][HISTORY_DEPTH];

  // Run bookkeeping
  bit quiet          = 1'b0;
  bit long_hold_done = 1'b0;
  int send_gap       = 0;
  int hold_left      = 0;
  int n_sent         = 0;
  int n_dropped      = 0;
  int n_shifts       = 0;
  int n_saturated    = 0;
  int n_results      = 0;
  int mismatches     = 0;

  pad_input_history_conditioner_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // 100 MHz clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    for (int p = 0; p < NUM_PORTS; p++) begin
      last_btn[p]   = '0;
      last_dir[p]   = '0;
      shift_seen[p] = 1'b0;
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
        hist_val[p][k] = '0;
        hist_cnt[p][k] = '0;
        hist_str[p][k] = 1'b0;
      end
    end
  end

  // Thresholded stick: bit0 right, bit1 left, bit2 down, bit3 up
  function automatic logic [DIR_W-1:0] quantize_stick(int x, int y, int t);
    logic [DIR_W-1:0] d;
    d = '0;
    d[0] = x > t;
    d[1] = x < -t;
    d[2] = y < -t;
    d[3] = y > t;
    return d;
  endfunction

  // Scoreboard model: updates the shadow state, returns 1 when a result is due
  function automatic bit condition_sample(input in_item_t s, output out_item_t r);
    int unsigned      c;
    logic [DIR_W-1:0] dir;
    logic [BTN_W-1:0] drive;
    logic [BTN_W-1:0] headv;
    logic             by_stick;
    logic             tilt;
    logic             shifted;
    r = '0;
    c = 32'(s.controller);
    if (!s.connected || c >= NUM_PORTS) begin
      n_dropped++;
      return 1'b0;
    end
    dir      = quantize_stick($signed(s.stick_x), $signed(s.stick_y), cfg_dir_thr);
    by_stick = cfg_mode_mask[c];
    tilt     = by_stick &&
               (quantize_stick($signed(s.stick_x), $signed(s.stick_y), cfg_strong_thr) != '0);
    drive    = by_stick ? {4'd0, dir, 8'd0} : s.buttons;
    headv    = by_stick ? {4'd0, last_dir[c], 8'd0} : last_btn[c];

    // head entry absorbs the previous sample
    hist_val[c][0] = headv;
    if (hist_cnt[c][0] != COUNT_MAX) hist_cnt[c][0]++;
    hist_str[c][0] = tilt;

    // d-pad change pushes the history one deeper
    shifted = (last_btn[c] & DPAD_MASK) != (drive & DPAD_MASK);
    if (shifted) begin
      for (int j = HISTORY_DEPTH - 1; j > 0; j--) begin
        hist_val[c][j] = hist_val[c][j-1];
        hist_cnt[c][j] = hist_cnt[c][j-1];
        hist_str[c][j] = hist_str[c][j-1];
      end
      hist_val[c][0] = '0;
      hist_cnt[c][0] = '0;
      hist_str[c][0] = 1'b0;
      shift_seen[c]  = 1'b1;
      n_shifts++;
    end

    r.port            = s.controller;
    r.held_buttons    = s.buttons;
    r.new_buttons     = ~last_btn[c] & s.buttons;
    r.stick_dir       = dir;
    r.new_stick_dir   = ~last_dir[c] & dir;
    r.history_shifted = shifted;
    r.head_value      = hist_val[c][0];
    r.head_hold_count = hist_cnt[c][0];
    r.head_strong     = hist_str[c][0];
    if (r.head_hold_count == COUNT_MAX) n_saturated++;

    last_dir[c] = dir;
    last_btn[c] = s.buttons;
    return 1'b1;
  endfunction

  // Driver: offers pending samples, predicts on acceptance
  always @(posedge clk_i) begin
    out_item_t r;
    logic      nv;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        n_sent++;
        if (condition_sample(in_item, r)) expected_results.push_back(r);
      end
      nv = in_valid && !in_ready_o;
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_samples.size() > 0) begin
          if (!quiet && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(0, 12);
          end else begin
            in_item <= pending_samples.pop_front();
            nv = 1'b1;
          end
        end
      end
      in_valid <= nv;
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Monitor: checks results, stalls the output side
  always @(posedge clk_i) begin
    out_item_t e;
    logic      nr;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        n_results++;
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got port %0d buttons %0h",
                   $time, out_item_o.port, out_item_o.held_buttons);
        end else begin
          e = expected_results.pop_front();
          check_field("port", e.port, out_item_o.port);
          check_field("held_buttons", e.held_buttons, out_item_o.held_buttons);
          check_field("new_buttons", e.new_buttons, out_item_o.new_buttons);
          check_field("stick_dir", e.stick_dir, out_item_o.stick_dir);
          check_field("new_stick_dir", e.new_stick_dir, out_item_o.new_stick_dir);
          check_field("history_shifted", e.history_shifted, out_item_o.history_shifted);
          check_field("head_value", e.head_value, out_item_o.head_value);
          check_field("head_hold_count", e.head_hold_count, out_item_o.head_hold_count);
          check_field("head_strong", e.head_strong, out_item_o.head_strong);
        end
      end
      nr = 1'b1;
      if (hold_left > 0) begin
        hold_left--;
        nr = 1'b0;
      end else if (!long_hold_done && n_results >= 120) begin
        // long back-pressure so the input side backs up
        long_hold_done = 1'b1;
        hold_left = 200;
        nr = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(0, 12);
        nr = 1'b0;
      end
      out_ready <= nr;
    end
  end

  task automatic queue_sample(int port, bit conn, logic [BTN_W-1:0] btn, int sx, int sy);
    in_item_t s;
    s.controller = 2'(port);
    s.connected  = conn;
    s.buttons    = btn;
    s.stick_x    = 8'(sx);
    s.stick_y    = 8'(sy);
    pending_samples.push_back(s);
  endtask

  // One stick axis: 0 inside the dead zone, 1 beyond +t, 2 beyond -t
  function automatic int pick_axis(int sel, int t);
    if (sel == 1 && t < 127) return $urandom_range(t + 1, 127);
    if (sel == 2) return -int'($urandom_range(t + 1, 128));
    return int'($urandom_range(0, 2 * t)) - t;
  endfunction

  // Runs of steady direction per port with random other buttons, plus noise
  task automatic queue_random_runs(int target, bit with_long_run);
    int made;
    int port;
    int len;
    int xsel;
    int ysel;
    int sx;
    int sy;
    int noise_pct;
    logic [DIR_W-1:0] d;
    made = 0;
    while (made < target) begin
      port = $urandom_range(0, NUM_PORTS - 1);
      len  = $urandom_range(1, 12);
      if (with_long_run && made > target / 3) begin
        len = 262;
        with_long_run = 1'b0;
      end
      noise_pct = (len > 12) ? 0 : 15;
      xsel = $urandom_range(0, 2);
      ysel = $urandom_range(0, 2);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 99) < noise_pct) begin
          queue_sample(int'($urandom_range(0, NUM_PORTS - 1)), 1'($urandom_range(0, 1)),
                       16'($urandom),
                       int'($urandom_range(0, 255)) - 128,
                       int'($urandom_range(0, 255)) - 128);
          if (pending_samples[$].connected) made++;
        end else begin
          sx = pick_axis(xsel, cfg_dir_thr);
          sy = pick_axis(ysel, cfg_dir_thr);
          d  = quantize_stick(sx, sy, cfg_dir_thr);
          queue_sample(port, 1'b1, (16'($urandom) & 16'hF0FF) | {4'd0, d, 8'd0}, sx, sy);
          made++;
        end
      end
    end
  endtask

  // Wait until everything offered has been taken and checked
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_samples.size() > 0 || in_valid || expected_results.size() > 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_settings(logic [MODE_W-1:0] mask, logic [THR_W-1:0] dthr,
                                logic [THR_W-1:0] sthr);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_STICK_MODE;
    cfg_wdata <= CFG_W'(mask);
    @(posedge clk_i);
    cfg_idx   <= REG_DIR_THR;
    cfg_wdata <= dthr;
    @(posedge clk_i);
    cfg_idx   <= REG_STRONG_THR;
    cfg_wdata <= sthr;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    cfg_mode_mask  = mask;
    cfg_dir_thr    = dthr;
    cfg_strong_thr = sthr;
  endtask

  // Stimulus sequence
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // button mode at reset settings: field extremes, threshold edges, drops
    queue_sample(0, 1, 16'h0000, 0, 0);
    queue_sample(0, 1, 16'hFFFF, 127, -128);
    queue_sample(0, 1, 16'hFFFF, -128, 127);
    queue_sample(0, 1, 16'h0000, 20, -20);
    queue_sample(1, 1, 16'h0100, 21, -21);
    queue_sample(1, 1, 16'h0100, -21, 21);
    queue_sample(2, 0, 16'hFFFF, 127, 127);
    queue_sample(2, 1, 16'h00FF, -20, 20);
    queue_sample(3, 1, 16'h0800, 51, 50);
    queue_sample(3, 1, 16'h0A00, -51, -50);
    queue_sample(3, 0, 16'h0400, 0, 0);
    queue_sample(3, 1, 16'h0A00, 0, 0);
    wait_drained();

    // stick mode on all ports: strong edge, stick vs button d-pad compare
    apply_settings(4'hF, 7'd20, 7'd50);
    queue_sample(0, 1, 16'h0000, 0, 0);
    queue_sample(0, 1, 16'h0100, 50, 0);
    queue_sample(0, 1, 16'h0100, 51, 0);
    queue_sample(0, 1, 16'h0100, 127, 0);
    queue_sample(1, 1, 16'h0000, -51, -51);
    queue_sample(1, 1, 16'h0600, -128, -128);
    queue_sample(1, 1, 16'h0600, -21, -21);
    queue_sample(2, 1, 16'hFFFF, 0, 127);
    queue_sample(2, 1, 16'h0800, 0, 21);
    queue_sample(2, 1, 16'h0800, 0, 21);
    queue_sample(3, 0, 16'hFFFF, -128, -128);
    queue_sample(3, 1, 16'h0000, 0, -128);
    wait_drained();

    // random runs across settings, extremes included
    apply_settings(4'h0, 7'd20, 7'd50);
    queue_random_runs(320, 1'b1);
    wait_drained();
    apply_settings(4'hF, 7'd35, 7'd90);
    queue_random_runs(320, 1'b1);
    wait_drained();
    apply_settings(4'($urandom), 7'd0, 7'd0);
    queue_random_runs(230, 1'b0);
    wait_drained();
    apply_settings(4'($urandom), 7'd127, 7'd127);
    queue_random_runs(230, 1'b0);
    wait_drained();
    apply_settings(4'h5, 7'($urandom), 7'($urandom));
    queue_random_runs(230, 1'b0);
    wait_drained();

    // closing stretch at full rate on both sides
    quiet = 1'b1;
    apply_settings(4'hA, 7'($urandom), 7'($urandom));
    queue_random_runs(200, 1'b0);
    wait_drained();
    repeat (8) @(posedge clk_i);

    $display("Covered %0d samples (%0d dropped), %0d results, %0d history shifts,",
             n_sent, n_dropped, n_results, n_shifts);
    $display("%0d saturated hold counts, button and stick modes, thresholds 0 to 127.",
             n_saturated);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

/* filelist.f */
design/phic_pkg.sv
design/phic_cell.sv
design/phic_front.sv
design/pad_input_history_conditioner_core.sv
tb/pad_input_history_conditioner_core_tb.sv
